[design/cfv_pkg.sv]
package cfv_pkg;

   localparam int unsigned FRAME_LEN = 20;
   localparam logic [7:0] FRAME_LEN_BYTE = 8'd20;

   typedef enum logic [1:0] {
      ACT_BYTE  = 2'd0,
      ACT_GAP   = 2'd1,
      ACT_TABLE = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      V_SYNC      = 4'd0,
      V_LENGTH    = 4'd1,
      V_SUM       = 4'd2,
      V_OPCODE    = 4'd3,
      V_ARG       = 4'd4,
      V_REPLAY    = 4'd5,
      V_QUEUE     = 4'd6,
      V_NOT_ARMED = 4'd7,
      V_ACCEPTED  = 4'd8
   } verdict_type;

   typedef enum logic [2:0] {
      CSR_ENABLE  = 3'd0,
      CSR_SYNC    = 3'd1,
      CSR_ARMED   = 3'd2,
      CSR_ENTRIES = 3'd3,
      CSR_CEILING = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_READ,
      ST_DECIDE,
      ST_COUNT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       store_byte;
      logic       clear_fill;
      logic       start_search;
      logic       step_search;
      logic       decide;
      logic       truncated;
      logic       count;
   } ctrl_type;

   typedef struct packed {
      logic       fill_nonzero;
      logic       frame_full;
      logic       search_done;
      logic       pre_fail;
   } stat_type;

endpackage

[design/cfv_if.sv]
interface cfv_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [7:0]  byte_value;
   logic        queue_has_room;
   logic [3:0]  entry_index;
   logic [7:0]  entry_opcode;
   logic [31:0] entry_arg_min;
   logic [31:0] entry_arg_max;
   logic        entry_critical;
   modport source (output valid, action, byte_value, queue_has_room, entry_index,
      entry_opcode, entry_arg_min, entry_arg_max, entry_critical, input ready);
   modport sink (input valid, action, byte_value, queue_has_room, entry_index,
      entry_opcode, entry_arg_min, entry_arg_max, entry_critical, output ready);
endinterface

interface cfv_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  verdict;
   logic [7:0]  cmd_opcode;
   logic [31:0] exec_time;
   logic [31:0] argument;
   logic [31:0] frame_counter;
   logic        first_of_reason;
   logic [31:0] examined_count;
   logic [31:0] accepted_count;
   logic [31:0] reason_count;
   modport source (output valid, verdict, cmd_opcode, exec_time, argument, frame_counter,
      first_of_reason, examined_count, accepted_count, reason_count, input ready);
   modport sink (input valid, verdict, cmd_opcode, exec_time, argument, frame_counter,
      first_of_reason, examined_count, accepted_count, reason_count, output ready);
endinterface

interface cfv_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[design/cfv_ram.sv]
module cfv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[design/cfv_ctrl.sv]
module cfv_ctrl
   import cfv_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      enable,
   input  logic      req_valid,
   input  logic [1:0] req_action,
   output logic      req_ready,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   input  stat_type  stat,
   output ctrl_type  ctrl
);
   state_type state_ff, state_in;
   logic      take;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_OUT);
      take      = req_valid && req_ready && enable;
      unique case (state_ff)
         ST_IDLE: begin
            if (take && req_action == ACT_GAP && stat.fill_nonzero) begin
               ctrl.clear_fill = 1'b1;
               ctrl.truncated  = 1'b1;
               state_in        = ST_COUNT;
            end else if (take && req_action == ACT_BYTE) begin
               ctrl.store_byte = 1'b1;
               if (stat.frame_full) begin
                  ctrl.start_search = 1'b1;
                  state_in          = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            ctrl.step_search = 1'b1;
            if (stat.pre_fail || stat.search_done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            ctrl.decide = 1'b1;
            state_in    = ST_COUNT;
         end
         ST_COUNT: begin
            ctrl.count = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

[design/cfv_datapath.sv]
module cfv_datapath
   import cfv_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  ctrl_type    ctrl,
   output stat_type    stat,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_byte_value,
   input  logic        req_queue_has_room,
   input  logic [3:0]  req_entry_index,
   input  logic [7:0]  req_entry_opcode,
   input  logic [31:0] req_entry_arg_min,
   input  logic [31:0] req_entry_arg_max,
   input  logic        req_entry_critical,
   input  logic [31:0] sync_word,
   input  logic [7:0]  armed_opcode,
   input  logic [4:0]  entries_in_use,
   input  logic [31:0] count_ceiling,
   output logic [3:0]  verdict,
   output logic [7:0]  cmd_opcode,
   output logic [31:0] exec_time,
   output logic [31:0] argument,
   output logic [31:0] frame_counter,
   output logic        first_of_reason,
   output logic [31:0] examined_count,
   output logic [31:0] accepted_count,
   output logic [31:0] reason_count
);
   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   logic [7:0]  frame_ff [FRAME_LEN];
   logic [4:0]  fill_ff;
   logic [15:0] sum_ff, sum_in;
   logic [31:0] last_ff, examined_ff, accepted_ff;
   logic [31:0] rej_ff [8];
   logic [7:0]  mask_ff;
   logic [CW-1:0] idx_ff;
   logic [CW-1:0] limit;
   logic        room_ff;
   logic [3:0]  verdict_ff, verdict_in;
   logic        first_ff;
   logic [31:0] reason_ff;
   logic        hit_ff;
   logic [AW-1:0] hit_idx_ff;
   logic        trunc_ff;

   logic          tbl_we;
   logic [AW-1:0] tbl_waddr, tbl_raddr;
   logic [8:0]    key_rd;
   logic [63:0]   rng_rd;
   logic [8:0]    scan_key;
   logic [16:0]   acc;
   logic [31:0]   sync_v, sum_v;
   logic          in_range_idx, key_hit;

   assign tbl_we    = req_valid && req_ready && req_action == ACT_TABLE
                      && ({28'd0, req_entry_index} < 32'(TABLE_ENTRIES));
   assign tbl_waddr = AW'(req_entry_index);
   assign limit     = ({27'd0, entries_in_use} > 32'(TABLE_ENTRIES)) ? CW'(TABLE_ENTRIES)
                                                                      : CW'(entries_in_use);

   cfv_ram #(.WIDTH(9), .DEPTH(TABLE_ENTRIES)) u_keys (
      .clock(clock), .wr_en(tbl_we), .wr_addr(tbl_waddr),
      .wr_data({req_entry_critical, req_entry_opcode}),
      .rd_addr(tbl_raddr), .rd_data(key_rd));

   cfv_ram #(.WIDTH(9), .DEPTH(TABLE_ENTRIES)) u_scan (
      .clock(clock), .wr_en(tbl_we), .wr_addr(tbl_waddr),
      .wr_data({req_entry_critical, req_entry_opcode}),
      .rd_addr(AW'(idx_ff)), .rd_data(scan_key));

   cfv_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_ranges (
      .clock(clock), .wr_en(tbl_we), .wr_addr(tbl_waddr),
      .wr_data({req_entry_arg_max, req_entry_arg_min}),
      .rd_addr(tbl_raddr), .rd_data(rng_rd));

   assign tbl_raddr  = hit_idx_ff;

   // scan pipeline: idx_ff addresses, key arrives in the next cycle for idx_ff-1
   logic          scan_valid_ff;
   logic [CW-1:0] scan_idx_ff;

   assign in_range_idx = scan_valid_ff && (scan_idx_ff < limit);
   assign key_hit      = in_range_idx && (scan_key[7:0] == frame_ff[9]);

   assign sync_v = {frame_ff[3], frame_ff[2], frame_ff[1], frame_ff[0]};
   assign sum_v  = {16'd0, frame_ff[19], frame_ff[18]};

   assign stat.fill_nonzero = (fill_ff != 5'd0);
   assign stat.frame_full   = (fill_ff == 5'(FRAME_LEN - 1));
   assign stat.search_done  = hit_ff || key_hit
                              || (scan_valid_ff && scan_idx_ff >= limit);
   assign stat.pre_fail     = (sync_v != sync_word) || (frame_ff[8] != FRAME_LEN_BYTE)
                              || (sum_v[15:0] != ~sum_ff);

   assign acc    = {1'b0, sum_ff} + {9'd0, req_byte_value};
   assign sum_in = acc[15:0] + {15'd0, acc[16]};

   logic [31:0] cnt_w, arg_w;
   assign cnt_w = {frame_ff[7], frame_ff[6], frame_ff[5], frame_ff[4]};
   assign arg_w = {frame_ff[17], frame_ff[16], frame_ff[15], frame_ff[14]};

   always_comb begin
      verdict_in = V_ACCEPTED;
      if (sync_v != sync_word) verdict_in = V_SYNC;
      else if (frame_ff[8] != FRAME_LEN_BYTE) verdict_in = V_LENGTH;
      else if (sum_v[15:0] != ~sum_ff) verdict_in = V_SUM;
      else if (!hit_ff) verdict_in = V_OPCODE;
      else if (arg_w < rng_rd[31:0] || arg_w > rng_rd[63:32]) verdict_in = V_ARG;
      else if (cnt_w <= last_ff) verdict_in = V_REPLAY;
      else if (key_rd[8] && armed_opcode != frame_ff[9]) verdict_in = V_NOT_ARMED;
      else if (!room_ff) verdict_in = V_QUEUE;
   end

   logic [2:0]  why;
   logic [31:0] rej_cur;
   assign why     = verdict_ff[2:0];
   assign rej_cur = rej_ff[why];

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         sum_ff        <= '0;
         last_ff       <= '0;
         examined_ff   <= '0;
         accepted_ff   <= '0;
         mask_ff       <= '0;
         scan_valid_ff <= 1'b0;
         hit_ff        <= 1'b0;
         trunc_ff      <= 1'b0;
         for (int k = 0; k < 8; k++) rej_ff[k] <= '0;
      end else begin
         if (ctrl.store_byte) begin
            frame_ff[fill_ff] <= req_byte_value;
            room_ff           <= req_queue_has_room;
            if (fill_ff < 5'd18) begin
               sum_ff <= (fill_ff == 5'd0) ? {8'd0, req_byte_value} : sum_in;
            end
            fill_ff <= ctrl.start_search ? 5'd0 : fill_ff + 5'd1;
         end
         if (ctrl.clear_fill) begin
            fill_ff    <= '0;
            verdict_ff <= V_LENGTH;
         end
         if (ctrl.start_search) begin
            idx_ff        <= '0;
            scan_valid_ff <= 1'b0;
            hit_ff        <= 1'b0;
         end
         if (ctrl.step_search) begin
            idx_ff        <= idx_ff + 1'b1;
            scan_idx_ff   <= idx_ff;
            scan_valid_ff <= 1'b1;
            if (key_hit && !hit_ff) begin
               hit_ff     <= 1'b1;
               hit_idx_ff <= AW'(scan_idx_ff);
            end
         end
         if (ctrl.decide) begin
            verdict_ff <= verdict_in;
         end
         if (ctrl.count) begin
            if (examined_ff < count_ceiling) examined_ff <= examined_ff + 1'b1;
            if (verdict_ff == V_ACCEPTED) begin
               last_ff <= cnt_w;
               if (accepted_ff < count_ceiling) accepted_ff <= accepted_ff + 1'b1;
               first_ff  <= 1'b0;
               reason_ff <= '0;
            end else begin
               first_ff  <= !mask_ff[why];
               mask_ff[why] <= 1'b1;
               if (rej_cur < count_ceiling) begin
                  rej_ff[why] <= rej_cur + 1'b1;
                  reason_ff   <= rej_cur + 1'b1;
               end else begin
                  reason_ff <= rej_cur;
               end
            end
         end
         if (ctrl.store_byte || ctrl.clear_fill) begin
            trunc_ff <= ctrl.truncated;
         end
      end
   end

   assign verdict         = verdict_ff;
   assign first_of_reason = first_ff;
   assign reason_count    = reason_ff;
   assign examined_count  = examined_ff;
   assign accepted_count  = accepted_ff;
   assign cmd_opcode      = trunc_ff ? 8'd0 : frame_ff[9];
   assign exec_time       = trunc_ff ? 32'd0
                            : {frame_ff[13], frame_ff[12], frame_ff[11], frame_ff[10]};
   assign argument        = trunc_ff ? 32'd0 : arg_w;
   assign frame_counter   = trunc_ff ? 32'd0 : cnt_w;
endmodule

[design/command_frame_validator_core.sv]
// A frame's result passes ST_SEARCH, ST_READ, ST_DECIDE and ST_COUNT before ST_OUT offers it.
// A truncated frame's result goes from the gap transfer through ST_COUNT to ST_OUT.
// Throughput: one byte per cycle while assembling; the opcode table walk reads one
// table entry per cycle and sets the per-frame time.
// Reset: synchronous, active high; counters, fill count and the CSR registers clear,
// count_ceiling resets to all ones. Table contents are undefined until written.
module command_frame_validator_core
   import cfv_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16
) (
   input logic  clock,
   input logic  reset,
   cfv_req_if.sink   req,
   cfv_rsp_if.source rsp,
   cfv_csr_if.sink   csr
);
   logic        enable_ff;
   logic [31:0] sync_ff, ceiling_ff;
   logic [7:0]  armed_ff;
   logic [4:0]  entries_ff;
   ctrl_type    ctrl;
   stat_type    stat;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         sync_ff    <= '0;
         armed_ff   <= '0;
         entries_ff <= '0;
         ceiling_ff <= '1;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_ENABLE:  enable_ff  <= csr.data[0];
            CSR_SYNC:    sync_ff    <= csr.data;
            CSR_ARMED:   armed_ff   <= csr.data[7:0];
            CSR_ENTRIES: entries_ff <= csr.data[4:0];
            CSR_CEILING: ceiling_ff <= csr.data;
            default: ;
         endcase
      end
   end

   cfv_ctrl u_ctrl (
      .clock(clock), .reset(reset), .enable(enable_ff),
      .req_valid(req.valid), .req_action(req.action), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .stat(stat), .ctrl(ctrl));

   cfv_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .req_valid(req.valid), .req_ready(req.ready), .req_action(req.action),
      .req_byte_value(req.byte_value), .req_queue_has_room(req.queue_has_room),
      .req_entry_index(req.entry_index), .req_entry_opcode(req.entry_opcode),
      .req_entry_arg_min(req.entry_arg_min), .req_entry_arg_max(req.entry_arg_max),
      .req_entry_critical(req.entry_critical),
      .sync_word(sync_ff), .armed_opcode(armed_ff), .entries_in_use(entries_ff),
      .count_ceiling(ceiling_ff),
      .verdict(rsp.verdict), .cmd_opcode(rsp.cmd_opcode), .exec_time(rsp.exec_time),
      .argument(rsp.argument), .frame_counter(rsp.frame_counter),
      .first_of_reason(rsp.first_of_reason), .examined_count(rsp.examined_count),
      .accepted_count(rsp.accepted_count), .reason_count(rsp.reason_count));
endmodule

[design/cfv_checker.sv]
module cfv_checker
   import cfv_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  verdict,
   input logic        first_of_reason,
   input logic [31:0] reason_count
);
   a_no_accept_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input taken while result pending");
   a_verdict_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> verdict <= V_ACCEPTED) else $error("verdict out of range");
   a_accept_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && verdict == V_ACCEPTED) |-> (!first_of_reason && reason_count == 32'd0))
      else $error("accepted frame carries rejection data");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("result dropped");
endmodule

bind command_frame_validator_core cfv_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .verdict(rsp.verdict),
   .first_of_reason(rsp.first_of_reason), .reason_count(rsp.reason_count));

[dv/tb_command_frame_validator_core.sv]
module tb_command_frame_validator_core;
   import cfv_pkg::*;

   typedef struct {
      action_type  action;
      logic [7:0]  byte_value;
      logic        queue_has_room;
      logic [3:0]  entry_index;
      logic [7:0]  entry_opcode;
      logic [31:0] entry_arg_min;
      logic [31:0] entry_arg_max;
      logic        entry_critical;
   } uplink_item_type;

   typedef struct {
      logic [3:0]  verdict;
      logic [7:0]  cmd_opcode;
      logic [31:0] exec_time;
      logic [31:0] argument;
      logic [31:0] frame_counter;
      logic        first_of_reason;
      logic [31:0] examined_count;
      logic [31:0] accepted_count;
      logic [31:0] reason_count;
   } frame_verdict_type;

   class frame_scoreboard;
      logic        enable;
      logic [31:0] sync_word;
      logic [7:0]  armed_opcode;
      logic [4:0]  entries_in_use;
      logic [31:0] count_ceiling;
      logic [7:0]  frame_bytes [FRAME_LEN];
      int          fill;
      logic [31:0] last_counter;
      logic [31:0] examined_total;
      logic [31:0] accepted_total;
      logic [31:0] reason_totals [8];
      logic [7:0]  announced;
      logic [7:0]  key_opcode [16];
      logic        key_critical [16];
      logic [31:0] range_min [16];
      logic [31:0] range_max [16];
      frame_verdict_type pending [$];
      frame_verdict_type cur;
      int          errors;

      function new();
         enable = 0;
         sync_word = 0;
         armed_opcode = 0;
         entries_in_use = 0;
         count_ceiling = '1;
         fill = 0;
         last_counter = 0;
         examined_total = 0;
         accepted_total = 0;
         announced = 0;
         errors = 0;
         foreach (reason_totals[i]) reason_totals[i] = 0;
         foreach (key_opcode[i]) begin
            key_opcode[i] = 0;
            key_critical[i] = 0;
            range_min[i] = 0;
            range_max[i] = 0;
         end
      endfunction

      function void write_reg(csr_index_type idx, logic [31:0] d);
         case (idx)
            CSR_ENABLE: enable = d[0];
            CSR_SYNC: sync_word = d;
            CSR_ARMED: armed_opcode = d[7:0];
            CSR_ENTRIES: entries_in_use = d[4:0];
            CSR_CEILING: count_ceiling = d;
            default: ;
         endcase
      endfunction

      function logic [31:0] bumped(logic [31:0] c);
         return (c < count_ceiling) ? c + 32'd1 : c;
      endfunction

      function int searched();
         return (entries_in_use > 16) ? 16 : int'(entries_in_use);
      endfunction

      function int lookup(logic [7:0] op);
         for (int i = 0; i < searched(); i++) begin
            if (key_opcode[i] == op) return i;
         end
         return -1;
      endfunction

      function void refuse(verdict_type why);
         cur.verdict = why;
         cur.first_of_reason = !announced[why];
         announced[why] = 1'b1;
         reason_totals[why] = bumped(reason_totals[why]);
         cur.reason_count = reason_totals[why];
      endfunction

      function logic [31:0] le32(int pos);
         return {frame_bytes[pos+3], frame_bytes[pos+2], frame_bytes[pos+1], frame_bytes[pos]};
      endfunction

      function logic [15:0] frame_sum();
         logic [31:0] s;
         s = 0;
         for (int i = 0; i < 18; i++) begin
            s = s + {24'd0, frame_bytes[i]};
            s = (s + (s >> 16)) & 32'hFFFF;
         end
         return s[15:0] ^ 16'hFFFF;
      endfunction

      function void judge_frame(logic room);
         int hit;
         cur.cmd_opcode = frame_bytes[9];
         cur.exec_time = le32(10);
         cur.argument = le32(14);
         cur.frame_counter = le32(4);
         hit = lookup(frame_bytes[9]);
         if (le32(0) != sync_word) refuse(V_SYNC);
         else if (frame_bytes[8] != FRAME_LEN_BYTE) refuse(V_LENGTH);
         else if ({frame_bytes[19], frame_bytes[18]} != frame_sum()) refuse(V_SUM);
         else if (hit < 0) refuse(V_OPCODE);
         else if (cur.argument < range_min[hit] || cur.argument > range_max[hit])
            refuse(V_ARG);
         else if (cur.frame_counter <= last_counter) refuse(V_REPLAY);
         else if (key_critical[hit] && armed_opcode != frame_bytes[9]) refuse(V_NOT_ARMED);
         else if (!room) refuse(V_QUEUE);
         else begin
            last_counter = cur.frame_counter;
            accepted_total = bumped(accepted_total);
            cur.verdict = V_ACCEPTED;
         end
      endfunction

      function void note_transfer(uplink_item_type it);
         if (it.action == ACT_TABLE) begin
            key_opcode[it.entry_index] = it.entry_opcode;
            key_critical[it.entry_index] = it.entry_critical;
            range_min[it.entry_index] = it.entry_arg_min;
            range_max[it.entry_index] = it.entry_arg_max;
            return;
         end
         if (!enable || it.action == ACT_NONE) return;
         cur = '{default: 0};
         if (it.action == ACT_GAP) begin
            if (fill == 0) return;
            fill = 0;
            examined_total = bumped(examined_total);
            refuse(V_LENGTH);
         end else begin
            frame_bytes[fill] = it.byte_value;
            fill++;
            if (fill < FRAME_LEN) return;
            fill = 0;
            examined_total = bumped(examined_total);
            judge_frame(it.queue_has_room);
         end
         cur.examined_count = examined_total;
         cur.accepted_count = accepted_total;
         pending.push_back(cur);
      endfunction

      function void compare(string name, logic [31:0] e, logic [31:0] a);
         if (e !== a) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
            errors++;
         end
      endfunction

      function void check_result(frame_verdict_type got);
         frame_verdict_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual verdict %0d",
               $time, got.verdict);
            errors++;
            return;
         end
         e = pending.pop_front();
         compare("verdict", 32'(e.verdict), 32'(got.verdict));
         compare("cmd_opcode", 32'(e.cmd_opcode), 32'(got.cmd_opcode));
         compare("exec_time", e.exec_time, got.exec_time);
         compare("argument", e.argument, got.argument);
         compare("frame_counter", e.frame_counter, got.frame_counter);
         compare("first_of_reason", 32'(e.first_of_reason), 32'(got.first_of_reason));
         compare("examined_count", e.examined_count, got.examined_count);
         compare("accepted_count", e.accepted_count, got.accepted_count);
         compare("reason_count", e.reason_count, got.reason_count);
      endfunction
   endclass

   logic clock;
   logic reset;
   cfv_req_if req ();
   cfv_rsp_if rsp ();
   cfv_csr_if csr ();

   command_frame_validator_core dut (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp),
      .csr(csr)
   );

   frame_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_cycles = 0;
   int items_sent = 0;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp.ready = 1'b0;
         hold_cycles--;
      end else begin
         rsp.ready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      frame_verdict_type got;
      uplink_item_type it;
      if (!reset && rsp.valid && rsp.ready) begin
         got.verdict = rsp.verdict;
         got.cmd_opcode = rsp.cmd_opcode;
         got.exec_time = rsp.exec_time;
         got.argument = rsp.argument;
         got.frame_counter = rsp.frame_counter;
         got.first_of_reason = rsp.first_of_reason;
         got.examined_count = rsp.examined_count;
         got.accepted_count = rsp.accepted_count;
         got.reason_count = rsp.reason_count;
         sb.check_result(got);
      end
      if (!reset && req.valid && req.ready) begin
         it.action = action_type'(req.action);
         it.byte_value = req.byte_value;
         it.queue_has_room = req.queue_has_room;
         it.entry_index = req.entry_index;
         it.entry_opcode = req.entry_opcode;
         it.entry_arg_min = req.entry_arg_min;
         it.entry_arg_max = req.entry_arg_max;
         it.entry_critical = req.entry_critical;
         sb.note_transfer(it);
      end
      if (!reset && csr.valid && csr.ready)
         sb.write_reg(csr_index_type'(csr.index), csr.data);
   end

   task automatic send_item(uplink_item_type it);
      @(negedge clock);
      req.valid = 1'b1;
      req.action = it.action;
      req.byte_value = it.byte_value;
      req.queue_has_room = it.queue_has_room;
      req.entry_index = it.entry_index;
      req.entry_opcode = it.entry_opcode;
      req.entry_arg_min = it.entry_arg_min;
      req.entry_arg_max = it.entry_arg_max;
      req.entry_critical = it.entry_critical;
      do @(posedge clock); while (!req.ready);
      items_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req.valid = 1'b0;
         repeat ($urandom_range(0, 4)) @(negedge clock);
      end
   endtask

   function automatic uplink_item_type noise_item(action_type a);
      uplink_item_type it;
      it.action = a;
      it.byte_value = 8'($urandom);
      it.queue_has_room = 1'($urandom);
      it.entry_index = 4'($urandom);
      it.entry_opcode = 8'($urandom);
      it.entry_arg_min = $urandom;
      it.entry_arg_max = $urandom;
      it.entry_critical = 1'($urandom);
      return it;
   endfunction

   task automatic send_byte(logic [7:0] b, logic room);
      uplink_item_type it;
      it = noise_item(ACT_BYTE);
      it.byte_value = b;
      it.queue_has_room = room;
      send_item(it);
   endtask

   task automatic write_slot(int idx, logic [7:0] op, logic [31:0] lo, logic [31:0] hi,
                             logic crit);
      uplink_item_type it;
      it = noise_item(ACT_TABLE);
      it.entry_index = 4'(idx);
      it.entry_opcode = op;
      it.entry_arg_min = lo;
      it.entry_arg_max = hi;
      it.entry_critical = crit;
      send_item(it);
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] d);
      @(negedge clock);
      csr.valid = 1'b1;
      csr.index = idx;
      csr.data = d;
      do @(posedge clock); while (!csr.ready);
      @(negedge clock);
      csr.valid = 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req.valid = 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // kind: 0 clean, 1 sync, 2 length, 3 sum, 4 opcode, 5 arg, 6 replay, 7 no room
   task automatic send_frame(int kind, int cut, logic [31:0] counter_override = 0,
                             bit use_override = 0);
      logic [7:0]  fb [FRAME_LEN];
      logic [7:0]  op;
      logic [31:0] ctr;
      logic [31:0] arg;
      logic [31:0] when_field;
      logic [31:0] s;
      logic [63:0] span;
      int          slot;
      int          n;
      n = sb.searched();
      op = 8'($urandom);
      arg = $urandom;
      if (n > 0 && kind != 4) begin
         slot = sb.lookup(sb.key_opcode[$urandom_range(n - 1)]);
         op = sb.key_opcode[slot];
         if (sb.range_min[slot] <= sb.range_max[slot]) begin
            span = {32'd0, sb.range_max[slot]} - {32'd0, sb.range_min[slot]} + 64'd1;
            case ($urandom_range(3))
               0: arg = sb.range_min[slot];
               1: arg = sb.range_max[slot];
               default: arg = sb.range_min[slot] + 32'({$urandom, $urandom} % span);
            endcase
         end
         if (kind == 5) arg = (sb.range_max[slot] != '1) ? sb.range_max[slot] + 32'd1 : 32'd0;
      end
      ctr = sb.last_counter + 32'd1 + $urandom_range(0, 3);
      if (kind == 6) ctr = sb.last_counter - $urandom_range(0, 1);
      if (use_override) ctr = counter_override;
      when_field = $urandom;
      {fb[3], fb[2], fb[1], fb[0]} = sb.sync_word ^ ((kind == 1) ? 32'h1 << $urandom_range(31)
                                                                  : 32'd0);
      {fb[7], fb[6], fb[5], fb[4]} = ctr;
      fb[8] = (kind == 2) ? 8'($urandom_range(0, 19)) : FRAME_LEN_BYTE;
      fb[9] = op;
      {fb[13], fb[12], fb[11], fb[10]} = when_field;
      {fb[17], fb[16], fb[15], fb[14]} = arg;
      s = 0;
      for (int i = 0; i < 18; i++) begin
         s = s + {24'd0, fb[i]};
         s = (s + (s >> 16)) & 32'hFFFF;
      end
      s = s ^ 32'hFFFF;
      if (kind == 3) s = s ^ (32'h1 << $urandom_range(15));
      {fb[19], fb[18]} = s[15:0];
      for (int i = 0; i < FRAME_LEN; i++) begin
         if (cut > 0 && i == cut) begin
            send_item(noise_item(ACT_GAP));
            return;
         end
         send_byte(fb[i], (i == FRAME_LEN - 1) ? (kind != 7 && $urandom_range(9) != 0)
                                               : 1'($urandom));
      end
   endtask

   task automatic random_traffic(int count);
      int stop;
      int r;
      stop = items_sent + count;
      while (items_sent < stop) begin
         r = $urandom_range(99);
         if (r < 45) send_frame(0, 0);
         else if (r < 70) send_frame($urandom_range(1, 7), 0);
         else if (r < 78) send_frame(0, $urandom_range(1, 19));
         else if (r < 86) send_byte(8'($urandom), 1'($urandom));
         else if (r < 90) send_item(noise_item(ACT_GAP));
         else if (r < 94) send_item(noise_item(ACT_NONE));
         else begin
            uplink_item_type it;
            it = noise_item(ACT_TABLE);
            if ($urandom_range(1)) it.entry_arg_min = $urandom_range(0, 1000);
            send_item(it);
         end
      end
   endtask

   task automatic set_phase(int idle, int stall);
      send_idle_pct = idle;
      recv_stall_pct = stall;
   endtask

   initial begin
      reset = 1'b1;
      req.valid = 1'b0;
      req.action = ACT_NONE;
      req.byte_value = '0;
      req.queue_has_room = 1'b0;
      req.entry_index = '0;
      req.entry_opcode = '0;
      req.entry_arg_min = '0;
      req.entry_arg_max = '0;
      req.entry_critical = 1'b0;
      rsp.ready = 1'b1;
      csr.valid = 1'b0;
      csr.index = CSR_ENABLE;
      csr.data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < 16; i++)
         write_slot(i, 8'(i * 17), $urandom_range(0, 100), 32'($urandom_range(101, 100000)),
                    (i % 4) == 3);
      write_slot(0, 8'h00, 32'd0, 32'hFFFF_FFFF, 1'b0);
      write_slot(15, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      write_slot(14, 8'h11, 32'd0, 32'd0, 1'b0);
      write_slot(13, 8'h22, 32'd9, 32'd3, 1'b0);

      send_byte(8'hFF, 1'b1);
      send_item(noise_item(ACT_GAP));
      drain();
      write_csr(CSR_SYNC, 32'hEB90_146F);
      write_csr(CSR_ARMED, 32'h0000_0033);
      write_csr(CSR_ENTRIES, 32'd16);
      write_csr(CSR_CEILING, 32'hFFFF_FFFF);
      write_csr(CSR_ENABLE, 32'd1);

      send_item(noise_item(ACT_GAP));
      send_item(noise_item(ACT_NONE));
      for (int k = 0; k <= 7; k++) send_frame(k, 0);
      send_frame(0, 1);
      send_frame(0, 19);
      drain();

      set_phase(0, 0);
      random_traffic(150);
      drain();
      set_phase(55, 0);
      random_traffic(150);
      drain();
      write_csr(CSR_ENTRIES, 32'd0);
      write_csr(CSR_ARMED, 32'h0000_00FF);
      set_phase(0, 55);
      random_traffic(100);
      drain();
      write_csr(CSR_ENTRIES, 32'd5);
      write_csr(CSR_CEILING, 32'd1);
      set_phase(16, 16);
      random_traffic(120);
      drain();
      write_csr(CSR_ENABLE, 32'd0);
      send_frame(0, 0);
      send_frame(0, 0);
      drain();
      write_csr(CSR_ENABLE, 32'd1);
      write_csr(CSR_CEILING, 32'd40);
      write_csr(CSR_ENTRIES, 32'd16);
      write_csr(CSR_SYNC, 32'h0000_0000);
      set_phase(0, 0);
      hold_cycles = 400;
      random_traffic(200);
      drain();
      write_csr(CSR_CEILING, 32'hFFFF_FFFF);
      write_csr(CSR_SYNC, 32'hFFFF_FFFF);
      write_csr(CSR_ARMED, 32'h0000_0000);
      set_phase(55, 55);
      random_traffic(150);
      drain();
      write_csr(CSR_ARMED, 32'h0000_00FF);
      set_phase(16, 16);
      random_traffic(150);
      drain();
      set_phase(0, 0);
      send_frame(0, 0, 32'hFFFF_FFFF, 1);
      random_traffic(60);
      drain();

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #(12 * 1000000);
      $display("== FAIL ==");
      $finish;
   end

endmodule
